FILE: sv/quaternion_vector_rotate_core_defines.svh
// Assertion macros for the quaternion vector rotate core.
// No dependencies; included by files that carry concurrent checks.
`ifndef QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define QVR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qvr check failed");
`define QVR_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("qvr forbidden condition");
`else
`define QVR_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define QVR_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: sv/qvr_pkg.sv
// Shared types and default constants for the quaternion vector rotate core.
// No dependencies.
package qvr_pkg;
   localparam int COMPONENT_WIDTH_DEFAULT = 16;
   localparam int LANES = 3;

   typedef struct packed {
      logic valid;
      logic neg;
      logic sat;
      logic zero;
   } qvr_flags_type;
endpackage

FILE: sv/qvr_products.sv
// Front four pipeline stages: products, sums, second products, and numerator with flags.
// Depends on qvr_pkg.
module qvr_products
   import qvr_pkg::*;
#(
   parameter int CW = COMPONENT_WIDTH_DEFAULT,
   parameter int NW = 3 * CW + 6,
   parameter int NORM_W = 2 * CW + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_x,
   input  logic signed [CW-1:0] in_y,
   input  logic signed [CW-1:0] in_z,
   input  logic signed [CW-1:0] in_w,
   input  logic signed [CW-1:0] in_vx,
   input  logic signed [CW-1:0] in_vy,
   input  logic signed [CW-1:0] in_vz,
   output qvr_flags_type        out_flags [LANES],
   output logic [NW-1:0]        out_mag [LANES],
   output logic [NORM_W-1:0]    out_norm
);
   localparam int P1 = 2 * CW;
   localparam int SW = 2 * CW + 3;
   localparam int PW = SW + CW;

   // stage 1: all component products
   logic v1_ff;
   logic signed [P1-1:0] xx_ff, yy_ff, zz_ff, ww_ff, xvx_ff, yvy_ff, zvz_ff;
   logic signed [P1-1:0] yvz_ff, zvy_ff, zvx_ff, xvz_ff, xvy_ff, yvx_ff;
   logic signed [CW-1:0] q1_ff [4];
   logic signed [CW-1:0] vec1_ff [LANES];

   // stage 2: sums
   logic v2_ff;
   logic signed [SW-1:0] norm2_ff, s2_ff, d2_ff;
   logic signed [SW-1:0] c2_ff [LANES];
   logic signed [CW-1:0] q2_ff [4];
   logic signed [CW-1:0] vec2_ff [LANES];

   // stage 3: second products
   logic v3_ff;
   logic signed [PW-1:0] sv3_ff [LANES];
   logic signed [PW-1:0] du3_ff [LANES];
   logic signed [PW-1:0] wc3_ff [LANES];
   logic signed [SW-1:0] norm3_ff;

   // stage 4
   qvr_flags_type flags4_ff [LANES];
   logic [NW-1:0] mag4_ff [LANES];
   logic [NORM_W-1:0] norm4_ff;

   logic signed [NW-1:0] num_in [LANES];
   logic [NW-1:0] mag_in [LANES];
   logic [NW-1:0] sat_bound;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      xx_ff  <= P1'(in_x) * P1'(in_x);
      yy_ff  <= P1'(in_y) * P1'(in_y);
      zz_ff  <= P1'(in_z) * P1'(in_z);
      ww_ff  <= P1'(in_w) * P1'(in_w);
      xvx_ff <= P1'(in_x) * P1'(in_vx);
      yvy_ff <= P1'(in_y) * P1'(in_vy);
      zvz_ff <= P1'(in_z) * P1'(in_vz);
      yvz_ff <= P1'(in_y) * P1'(in_vz);
      zvy_ff <= P1'(in_z) * P1'(in_vy);
      zvx_ff <= P1'(in_z) * P1'(in_vx);
      xvz_ff <= P1'(in_x) * P1'(in_vz);
      xvy_ff <= P1'(in_x) * P1'(in_vy);
      yvx_ff <= P1'(in_y) * P1'(in_vx);
      q1_ff[0] <= in_x;
      q1_ff[1] <= in_y;
      q1_ff[2] <= in_z;
      q1_ff[3] <= in_w;
      vec1_ff[0] <= in_vx;
      vec1_ff[1] <= in_vy;
      vec1_ff[2] <= in_vz;
   end

   always_ff @(posedge clock) begin
      norm2_ff <= SW'(ww_ff) + SW'(xx_ff) + SW'(yy_ff) + SW'(zz_ff);
      s2_ff    <= SW'(ww_ff) - SW'(xx_ff) - SW'(yy_ff) - SW'(zz_ff);
      d2_ff    <= SW'(xvx_ff) + SW'(yvy_ff) + SW'(zvz_ff);
      c2_ff[0] <= SW'(yvz_ff) - SW'(zvy_ff);
      c2_ff[1] <= SW'(zvx_ff) - SW'(xvz_ff);
      c2_ff[2] <= SW'(xvy_ff) - SW'(yvx_ff);
      q2_ff    <= q1_ff;
      vec2_ff  <= vec1_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         sv3_ff[i] <= PW'(s2_ff) * PW'(vec2_ff[i]);
         du3_ff[i] <= PW'(d2_ff) * PW'(q2_ff[i]);
         wc3_ff[i] <= PW'(q2_ff[3]) * PW'(c2_ff[i]);
      end
      norm3_ff <= norm2_ff;
   end

   assign sat_bound = NW'({norm3_ff[NORM_W-1:0], {CW{1'b0}}});

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         num_in[i] = NW'(sv3_ff[i]) + (NW'(du3_ff[i]) <<< 1) + (NW'(wc3_ff[i]) <<< 1);
         mag_in[i] = num_in[i][NW-1] ? NW'(-num_in[i]) : NW'(num_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         if (reset) begin
            flags4_ff[i].valid <= 1'b0;
         end else begin
            flags4_ff[i].valid <= v3_ff;
         end
         flags4_ff[i].neg  <= num_in[i][NW-1];
         flags4_ff[i].sat  <= mag_in[i] >= sat_bound;
         flags4_ff[i].zero <= norm3_ff == '0;
         mag4_ff[i] <= mag_in[i];
      end
      norm4_ff <= norm3_ff[NORM_W-1:0];
   end

   assign out_flags = flags4_ff;
   assign out_mag   = mag4_ff;
   assign out_norm  = norm4_ff;
endmodule

FILE: sv/qvr_divider.sv
// Pipelined restoring divider, one quotient bit per stage, then round and clamp.
// Depends on qvr_pkg.
module qvr_divider
   import qvr_pkg::*;
#(
   parameter int CW = COMPONENT_WIDTH_DEFAULT,
   parameter int NW = 3 * CW + 6,
   parameter int NORM_W = 2 * CW + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  qvr_flags_type     in_flags,
   input  logic [NW-1:0]     in_mag,
   input  logic [NORM_W-1:0] in_norm,
   output logic              out_valid,
   output logic [CW-1:0]     out_rot
);
   logic [NORM_W-1:0] rem_ff [CW];
   logic [CW-1:0] quo_ff [CW];
   logic [CW-1:0] low_ff [CW];
   logic [NORM_W-1:0] norm_ff [CW];
   qvr_flags_type flags_ff [CW];

   for (genvar k = 0; k < CW; k++) begin : g_stage
      logic [NORM_W-1:0] rem_src;
      logic [CW-1:0] quo_src;
      logic [CW-1:0] low_src;
      logic [NORM_W-1:0] norm_src;
      qvr_flags_type flags_src;
      logic [NORM_W:0] trial;
      logic ge;

      if (k == 0) begin : g_first
         assign rem_src   = in_mag[CW +: NORM_W];
         assign quo_src   = '0;
         assign low_src   = in_mag[CW-1:0];
         assign norm_src  = in_norm;
         assign flags_src = in_flags;
      end else begin : g_next
         assign rem_src   = rem_ff[k-1];
         assign quo_src   = quo_ff[k-1];
         assign low_src   = low_ff[k-1];
         assign norm_src  = norm_ff[k-1];
         assign flags_src = flags_ff[k-1];
      end

      assign trial = {rem_src, low_src[CW-1-k]};
      assign ge    = trial >= {1'b0, norm_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            flags_ff[k].valid <= 1'b0;
         end else begin
            flags_ff[k].valid <= flags_src.valid;
         end
         flags_ff[k].neg  <= flags_src.neg;
         flags_ff[k].sat  <= flags_src.sat;
         flags_ff[k].zero <= flags_src.zero;
         rem_ff[k]  <= ge ? NORM_W'(trial - {1'b0, norm_src}) : NORM_W'(trial);
         quo_ff[k]  <= (quo_src << 1) | CW'(ge);
         low_ff[k]  <= low_src;
         norm_ff[k] <= norm_src;
      end
   end

   localparam logic [CW:0] POS_MAX = {2'b00, {(CW-1){1'b1}}};
   localparam logic [CW:0] NEG_MAX = {2'b01, {(CW-1){1'b0}}};

   qvr_flags_type fl;
   logic [CW:0] q_round;
   logic round_up;
   logic [CW-1:0] rot_in;
   logic valid_ff;
   logic [CW-1:0] rot_ff;

   assign fl       = flags_ff[CW-1];
   assign round_up = {rem_ff[CW-1], 1'b0} >= {1'b0, norm_ff[CW-1]};
   assign q_round  = {1'b0, quo_ff[CW-1]} + (CW+1)'(round_up);

   always_comb begin
      if (fl.zero) begin
         rot_in = '0;
      end else if (fl.neg) begin
         rot_in = (fl.sat || q_round > NEG_MAX) ? NEG_MAX[CW-1:0] : CW'(-q_round);
      end else begin
         rot_in = (fl.sat || q_round > POS_MAX) ? POS_MAX[CW-1:0] : q_round[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= fl.valid;
      end
      rot_ff <= rot_in;
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;
endmodule

FILE: sv/quaternion_vector_rotate_core.sv
// Quaternion vector rotate core, fully pipelined; its depth grows with COMPONENT_WIDTH.
// Throughput one request per cycle; busy is always low, the pipeline never stalls.
// The pipeline has four arithmetic stages plus one restoring-divider stage per
// quotient bit and a round/clamp stage. Synchronous active-high reset clears all
// valid bits; data registers are not reset. Results appear for one cycle on rsp_valid.
module quaternion_vector_rotate_core
   import qvr_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_quat_w,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_vec_z,
   output logic                              rsp_valid,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_rot_z
);
`include "quaternion_vector_rotate_core_defines.svh"

   localparam int CW = COMPONENT_WIDTH;
   // numerator holds |q|^2 * |v| with headroom for the doubled terms
   localparam int NW = 3 * CW + 6;
   // squared norm reaches 4 * 2^(2*CW-2), one bit spare
   localparam int NORM_W = 2 * CW + 2;
   localparam int LATENCY = CW + 5;

   qvr_flags_type flags [LANES];
   logic [NW-1:0] mag [LANES];
   logic [NORM_W-1:0] norm;
   logic [LANES-1:0] lane_valid;
   logic [CW-1:0] rot [LANES];

   // every request enters the pipeline; nothing ever holds it off
   assign busy = 1'b0;

   qvr_products #(
      .CW(CW),
      .NW(NW),
      .NORM_W(NORM_W)
   ) u_products (
      .clock(clock),
      .reset(reset),
      .in_valid(start),
      .in_x(req_quat_x),
      .in_y(req_quat_y),
      .in_z(req_quat_z),
      .in_w(req_quat_w),
      .in_vx(req_vec_x),
      .in_vy(req_vec_y),
      .in_vz(req_vec_z),
      .out_flags(flags),
      .out_mag(mag),
      .out_norm(norm)
   );

   // one divider lane per rotated component, sharing the norm
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      qvr_divider #(
         .CW(CW),
         .NW(NW),
         .NORM_W(NORM_W)
      ) u_divider (
         .clock(clock),
         .reset(reset),
         .in_flags(flags[i]),
         .in_mag(mag[i]),
         .in_norm(norm),
         .out_valid(lane_valid[i]),
         .out_rot(rot[i])
      );
   end

   assign rsp_valid = lane_valid[0];
   assign rsp_rot_x = rot[0];
   assign rsp_rot_y = rot[1];
   assign rsp_rot_z = rot[2];

   // lanes advance in lockstep
   `QVR_ASSERT_NEVER(a_lanes_aligned, clock, reset, lane_valid != {LANES{lane_valid[0]}})
   // each accepted request comes out after the fixed latency
   `QVR_ASSERT_IMPLIES(a_latency, clock, reset, start, ##LATENCY rsp_valid)
   // no response without a request the latency before
   `QVR_ASSERT_IMPLIES(a_no_spurious, clock, reset, rsp_valid, $past(start, LATENCY))
endmodule
